>>> hdl/sitra_pkg.sv
// Shared types, constants and the control store for the radix text converter.
package sitra_pkg;

	localparam int VALUE_BITS_DEF  = 32;
	localparam int DIGIT_SLOTS_DEF = 32;
	localparam int RADIX_W         = 5;
	localparam int CHAR_W          = 7;
	localparam int DIGIT_W         = 4;
	localparam int DIV_CHUNK       = 8;
	localparam int STEP_W          = 3;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h41;

	// step codes
	localparam logic [STEP_W-1:0] S_WAIT  = 3'd0;
	localparam logic [STEP_W-1:0] S_DIV   = 3'd1;
	localparam logic [STEP_W-1:0] S_STORE = 3'd2;
	localparam logic [STEP_W-1:0] S_SIGN  = 3'd3;
	localparam logic [STEP_W-1:0] S_RD    = 3'd4;
	localparam logic [STEP_W-1:0] S_EMIT  = 3'd5;
	localparam logic [STEP_W-1:0] S_ERR   = 3'd6;

	// output word kinds
	localparam logic [1:0] OK_NONE  = 2'd0;
	localparam logic [1:0] OK_SIGN  = 2'd1;
	localparam logic [1:0] OK_DIGIT = 2'd2;
	localparam logic [1:0] OK_ERR   = 2'd3;

	// branch conditions
	localparam logic [2:0] C_TRUE     = 3'd0;
	localparam logic [2:0] C_BAD      = 3'd1;
	localparam logic [2:0] C_DIV_DONE = 3'd2;
	localparam logic [2:0] C_MORE     = 3'd3;
	localparam logic [2:0] C_CNT_ZERO = 3'd4;

	typedef struct packed {
		logic              in_rdy;
		logic [1:0]        out_kind;
		logic              div_en;
		logic              store_en;
		logic              rd_en;
		logic [2:0]        cond;
		logic [STEP_W-1:0] tgt_t;
		logic [STEP_W-1:0] tgt_f;
	} ctrl_t;

	typedef struct packed {
		logic bad;
		logic div_done;
		logic more;
		logic cnt_zero;
		logic neg;
	} stat_t;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c       = '0;
		c.cond  = C_TRUE;
		c.tgt_t = S_WAIT;
		c.tgt_f = S_WAIT;
		case (step)
			S_WAIT: begin
				c.in_rdy = 1'b1;
				c.cond   = C_BAD;
				c.tgt_t  = S_ERR;
				c.tgt_f  = S_DIV;
			end
			S_DIV: begin
				c.div_en = 1'b1;
				c.cond   = C_DIV_DONE;
				c.tgt_t  = S_STORE;
				c.tgt_f  = S_DIV;
			end
			S_STORE: begin
				c.store_en = 1'b1;
				c.cond     = C_MORE;
				c.tgt_t    = S_DIV;
				c.tgt_f    = S_SIGN;
			end
			S_SIGN: begin
				c.out_kind = OK_SIGN;
				c.tgt_t    = S_RD;
			end
			S_RD: begin
				c.rd_en = 1'b1;
				c.tgt_t = S_EMIT;
			end
			S_EMIT: begin
				c.out_kind = OK_DIGIT;
				c.cond     = C_CNT_ZERO;
				c.tgt_t    = S_WAIT;
				c.tgt_f    = S_RD;
			end
			S_ERR: begin
				c.out_kind = OK_ERR;
				c.tgt_t    = S_WAIT;
			end
			default: begin
				c.tgt_t = S_WAIT;
			end
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] g;
		if (d < DIGIT_W'(10))
			g = CH_ZERO + CHAR_W'(d);
		else
			g = CH_ALPHA + CHAR_W'(d - DIGIT_W'(10));
		return g;
	endfunction

endpackage

>>> hdl/sitra_num_if.sv
// Input channel: value and radix words.
interface sitra_num_if import sitra_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic [RADIX_W-1:0]    radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink (input valid, input value, input radix, output ready);
endinterface

>>> hdl/sitra_text_if.sv
// Output channel: one character word per handshake.
interface sitra_text_if import sitra_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;
	logic              bad_radix;

	modport source (output valid, output char_code, output last, output bad_radix, input ready);
	modport sink (input valid, input char_code, input last, input bad_radix, output ready);
endinterface

>>> hdl/sitra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sitra_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/sitra_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
module sitra_seq import sitra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  go,
	output logic  in_ready,
	output logic  out_valid
);
	logic [STEP_W-1:0] step_q;
	logic              taken;

	assign ctrl      = ucode(step_q);
	assign in_ready  = ctrl.in_rdy;
	assign out_valid = (ctrl.out_kind != OK_NONE) && !(ctrl.out_kind == OK_SIGN && !stat.neg);
	assign go        = !(ctrl.in_rdy && !in_valid) && !(out_valid && !out_ready);

	always_comb begin
		case (ctrl.cond)
			C_TRUE:     taken = 1'b1;
			C_BAD:      taken = stat.bad;
			C_DIV_DONE: taken = stat.div_done;
			C_MORE:     taken = stat.more;
			C_CNT_ZERO: taken = stat.cnt_zero;
			default:    taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else if (go) begin
			step_q <= taken ? ctrl.tgt_t : ctrl.tgt_f;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output open together");
	a_err_return: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_ERR && go) |=> step_q == S_WAIT) else $error("error word not followed by wait");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(step_q)) else $error("step moved under stall");
endmodule

>>> hdl/sitra_dp.sv
// Datapath: magnitude load, chunked digit division, digit store and character build.
module sitra_dp import sitra_pkg::*; #(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl,
	input  logic                  go,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	output stat_t                 stat,
	output logic [CHAR_W-1:0]     char_code,
	output logic                  last,
	output logic                  bad_radix
);
	localparam int NCH  = (VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
	localparam int WW   = NCH * DIV_CHUNK;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int AW   = $clog2(DIGIT_SLOTS);
	localparam int CNTW = $clog2(DIGIT_SLOTS + 1);

	logic [WW-1:0]        work_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   radix_q;
	logic                 neg_q;
	logic [CHW-1:0]       chunk_q;
	logic [CNTW-1:0]      cnt_q;

	logic [VALUE_BITS-1:0] mag;
	logic [DIGIT_W-1:0]   rd_digit;
	logic [DIV_CHUNK-1:0] qbits;
	logic [DIGIT_W-1:0]   rem_nx;
	logic                 load;

	assign load = ctrl.in_rdy && go;
	assign mag  = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

	// restoring division of one chunk, one bit per stage
	always_comb begin
		logic [RADIX_W-1:0]  t;
		logic [DIGIT_W-1:0]  r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < DIV_CHUNK; i++) begin
			t = {r, work_q[WW-1-i]};
			if (t >= radix_q) begin
				qbits[DIV_CHUNK-1-i] = 1'b1;
				t = t - radix_q;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q  <= '0;
			chunk_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				work_q  <= WW'(mag);
				chunk_q <= '0;
				cnt_q   <= '0;
			end else if (ctrl.div_en) begin
				work_q  <= (work_q << DIV_CHUNK) | WW'(qbits);
				chunk_q <= (chunk_q == CHW'(NCH - 1)) ? '0 : chunk_q + CHW'(1);
			end else if (ctrl.store_en) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (ctrl.rd_en) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			radix_q <= radix;
			neg_q   <= value[VALUE_BITS-1];
			rem_q   <= '0;
		end else if (ctrl.div_en) begin
			rem_q <= rem_nx;
		end else if (ctrl.store_en) begin
			rem_q <= '0;
		end
	end

	sitra_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(DIGIT_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (ctrl.store_en),
		.waddr(cnt_q[AW-1:0]),
		.wdata(rem_q),
		.re   (ctrl.rd_en),
		.raddr(cnt_q[AW-1:0] - AW'(1)),
		.rdata(rd_digit)
	);

	assign stat.bad      = (radix < RADIX_MIN) || (radix > RADIX_MAX);
	assign stat.div_done = (chunk_q == CHW'(NCH - 1));
	assign stat.more     = (work_q != '0) && (cnt_q != CNTW'(DIGIT_SLOTS - 1));
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.neg      = neg_q;

	always_comb begin
		case (ctrl.out_kind)
			OK_SIGN: begin
				char_code = CH_MINUS;
				last      = 1'b0;
				bad_radix = 1'b0;
			end
			OK_DIGIT: begin
				char_code = glyph(rd_digit);
				last      = stat.cnt_zero;
				bad_radix = 1'b0;
			end
			OK_ERR: begin
				char_code = CH_NUL;
				last      = 1'b1;
				bad_radix = 1'b1;
			end
			default: begin
				char_code = CH_NUL;
				last      = 1'b0;
				bad_radix = 1'b0;
			end
		endcase
	end

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.store_en |-> cnt_q < CNTW'(DIGIT_SLOTS)) else $error("digit store overrun");
	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en |-> cnt_q != '0) else $error("read of empty digit store");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div_en |-> {1'b0, rem_q} < radix_q) else $error("partial remainder out of range");
endmodule

>>> hdl/signed_int_to_radix_ascii_unit.sv
// Flow: an accepted word is divided one digit at a time (d digits, N = ceil(VALUE_BITS/8) divide
// chunks per digit) and each remainder is stored; then the sign, if any, goes out, then the digits.
// Throughput: one conversion at a time; a new word is taken only once the last digit has gone out.
// Pace is set by the eight-bit-per-cycle divide chunk and the registered digit store read; a stalled output holds it.
// A bad radix gives its error word in the cycle after acceptance; input is taken again once that word is taken.
// Reset: arst_n clears the step counter, digit count and work register; the digit store is not cleared.
module signed_int_to_radix_ascii_unit import sitra_pkg::*; #(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sitra_num_if.sink   num,
	sitra_text_if.source text
);
	ctrl_t ctrl;
	stat_t stat;
	logic  go;

	sitra_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (num.valid),
		.out_ready(text.ready),
		.stat     (stat),
		.ctrl     (ctrl),
		.go       (go),
		.in_ready (num.ready),
		.out_valid(text.valid)
	);

	sitra_dp #(
		.VALUE_BITS (VALUE_BITS),
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.go       (go),
		.value    (num.value),
		.radix    (num.radix),
		.stat     (stat),
		.char_code(text.char_code),
		.last     (text.last),
		.bad_radix(text.bad_radix)
	);
endmodule
